// ----- hdl/bpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared field widths, codes and the result type of the allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int unsigned CFG_W     = 11;
	localparam int unsigned ORD_W     = 4;
	localparam int unsigned IDX_W     = 10;
	localparam int unsigned TAG_W     = 4;
	localparam int unsigned IN_TDATA_W  = 16;
	localparam int unsigned OUT_TDATA_W = 16;

	// Highest order count that fits the 4-bit tag next to the taken code.
	localparam int unsigned MAX_ORDERS = 15;

	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;
	localparam logic [TAG_W-1:0] TAKEN     = 4'd15;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

	typedef struct packed {
		logic             status;
		logic [IDX_W-1:0] page_index;
	} res_t;

endpackage

// ----- hdl/bpa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bpa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/bpa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator sequencer
// Runs the start-up layout, the allocate search and split, and the free merge
// as read-modify-write steps on the page memory; keeps the list heads.
// ----------------------------------------------------------------------------
module bpa_ctrl #(
	parameter int unsigned MAX_PAGES   = 1024,
	parameter int unsigned ORDER_COUNT = 11,
	localparam int unsigned AW = $clog2(MAX_PAGES),
	localparam int unsigned PW = $clog2(MAX_PAGES + 1),
	localparam int unsigned WW = bpa_pkg::TAG_W + 2 * PW
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bpa_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_kind,
	input  logic [bpa_pkg::ORD_W-1:0]   in_order,
	input  logic [bpa_pkg::IDX_W-1:0]   in_page,
	output logic                        res_valid,
	output bpa_pkg::res_t               res,
	input  logic                        res_ready,
	output logic                        ram_we,
	output logic [AW-1:0]               ram_waddr,
	output logic [WW-1:0]               ram_wdata,
	output logic [AW-1:0]               ram_raddr,
	input  logic [WW-1:0]               ram_rdata
);

	localparam int unsigned NORD = (ORDER_COUNT > bpa_pkg::MAX_ORDERS) ?
		bpa_pkg::MAX_ORDERS : ORDER_COUNT;
	localparam int unsigned OIW = $clog2(NORD);
	localparam logic [PW-1:0] NIL = PW'(MAX_PAGES);

	typedef struct packed {
		logic [bpa_pkg::TAG_W-1:0] tag;
		logic [PW-1:0]             nxt;
		logic [PW-1:0]             prv;
	} word_t;

	typedef enum logic [3:0] {
		S_LAY, S_CLR, S_REM, S_IDLE, S_ASRCH, S_AREAD, S_ANPREV, S_SPLIT,
		S_PUSH, S_PUSH2, S_FCHK, S_FTAG, S_FUNP, S_FUNN, S_FIN
	} state_t;

	state_t state_q;

	logic [bpa_pkg::CFG_W-1:0] usable_q;
	logic [PW-1:0]             pages_q, base_q, step_q;
	logic [3:0]                ocnt_q, top_q;
	logic [AW-1:0]             addr_q;
	logic [PW-1:0]             head_q [NORD];
	logic                      kind_q;
	logic [3:0]                ord_q, o_q;
	logic [PW-1:0]             cur_q, r_q, b_q, pv_q, nx_q, pp_q, ra_q;
	logic                      fwd_q;
	word_t                     fwd_word_q;
	bpa_pkg::res_t             res_q;

	// Geometry of the layout, computed from the page count register.
	logic [PW-1:0] pages_c, step_c, base_c;
	logic [4:0]    bl_c;
	logic [3:0]    ocnt_c, top_c;

	always_comb begin
		pages_c = (32'(usable_q) > 32'(MAX_PAGES)) ? NIL : PW'(usable_q);
		bl_c = '0;
		for (int i = 0; i < PW; i++) begin
			if (pages_c[i]) begin
				bl_c = 5'(i + 1);
			end
		end
		ocnt_c = (bl_c > 5'(NORD)) ? 4'(NORD) : bl_c[3:0];
		top_c  = ocnt_c - 4'd1;
		step_c = PW'(1) << top_c;
		base_c = (pages_c >> top_c) << top_c;
	end

	// Read data, with the write of the same cycle forwarded.
	word_t rdat;
	assign rdat = fwd_q ? fwd_word_q : word_t'(ram_rdata);

	logic [PW-1:0]  hd, bx, cpos, cnxt, cprv, pshift;
	logic [3:0]     om1;
	logic [PW:0]    u;
	logic           chk_ok, in_top;
	word_t          wword;

	always_comb begin
		hd     = head_q[o_q[OIW-1:0]];
		om1    = o_q - 4'd1;
		u      = (PW + 1)'(r_q) + ((PW + 1)'(1) << om1);
		bx     = cur_q ^ (PW'(1) << o_q);
		chk_ok = ((5'(o_q) + 5'd1) < 5'(ocnt_q)) && (bx < pages_q);
		pshift = pages_q >> om1;
		cpos   = PW'(addr_q);
		in_top = (ocnt_q != 4'd0) && (cpos < base_q) && ((cpos & (step_q - PW'(1))) == '0);
		cnxt   = ((cpos + step_q) < base_q) ? (cpos + step_q) : NIL;
		cprv   = (cpos == '0) ? NIL : (cpos - step_q);

		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_raddr = '0;
		wword     = '{tag: bpa_pkg::TAKEN, nxt: '0, prv: '0};
		case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = addr_q;
				if (in_top) begin
					wword = '{tag: top_q, nxt: cnxt, prv: cprv};
				end
			end
			S_REM: begin
				if (o_q != 4'd0 && pshift[0]) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(ra_q);
					wword     = '{tag: om1, nxt: NIL, prv: NIL};
				end
			end
			S_ASRCH: begin
				ram_raddr = AW'(hd);
			end
			S_AREAD: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(r_q);
				wword     = '{tag: bpa_pkg::TAKEN, nxt: rdat.nxt, prv: rdat.prv};
				ram_raddr = AW'(rdat.nxt);
			end
			S_ANPREV: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(nx_q);
				wword     = '{tag: rdat.tag, nxt: rdat.nxt, prv: NIL};
			end
			S_PUSH: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(pp_q);
				wword     = '{tag: o_q, nxt: hd, prv: NIL};
				ram_raddr = AW'(hd);
			end
			S_PUSH2: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(nx_q);
				wword     = '{tag: rdat.tag, nxt: rdat.nxt, prv: pp_q};
			end
			S_FCHK: begin
				ram_raddr = AW'(bx);
			end
			S_FTAG: begin
				if (rdat.tag == o_q) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(b_q);
					wword     = '{tag: bpa_pkg::TAKEN, nxt: rdat.nxt, prv: rdat.prv};
					ram_raddr = (rdat.prv < NIL) ? AW'(rdat.prv) : AW'(rdat.nxt);
				end
			end
			S_FUNP: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(pv_q);
				wword     = '{tag: rdat.tag, nxt: nx_q, prv: rdat.prv};
				ram_raddr = AW'(nx_q);
			end
			S_FUNN: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(nx_q);
				wword     = '{tag: rdat.tag, nxt: rdat.nxt, prv: pv_q};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
		ram_wdata = wword;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LAY;
			usable_q <= bpa_pkg::CFG_RESET;
			fwd_q    <= 1'b0;
		end else begin
			fwd_q      <= ram_we && (ram_waddr == ram_raddr);
			fwd_word_q <= wword;
			case (state_q)
				S_LAY: begin
					pages_q <= pages_c;
					ocnt_q  <= ocnt_c;
					top_q   <= top_c;
					step_q  <= step_c;
					base_q  <= base_c;
					addr_q  <= '0;
					for (int i = 0; i < NORD; i++) begin
						head_q[i] <= NIL;
					end
					state_q <= S_CLR;
				end
				S_CLR: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == AW'(MAX_PAGES - 1)) begin
						ra_q <= base_q;
						o_q  <= top_q;
						if (ocnt_q == 4'd0) begin
							state_q <= S_IDLE;
						end else begin
							head_q[top_q[OIW-1:0]] <= '0;
							state_q <= S_REM;
						end
					end
				end
				S_REM: begin
					if (o_q == 4'd0) begin
						state_q <= S_IDLE;
					end else begin
						if (pshift[0]) begin
							head_q[om1[OIW-1:0]] <= ra_q;
							ra_q <= ra_q + (PW'(1) << om1);
						end
						o_q <= om1;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						kind_q <= in_kind;
						ord_q  <= in_order;
						o_q    <= in_order;
						cur_q  <= PW'(in_page);
						res_q  <= '{status: bpa_pkg::ST_FAIL, page_index: '0};
						if (in_order >= ocnt_q) begin
							state_q <= S_FIN;
						end else if (in_kind == bpa_pkg::KIND_ALLOC) begin
							state_q <= S_ASRCH;
						end else if (32'(in_page) >= 32'(pages_q)) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_FCHK;
						end
					end
				end
				S_ASRCH: begin
					if (o_q >= ocnt_q) begin
						state_q <= S_FIN;
					end else if (hd >= NIL) begin
						o_q <= o_q + 4'd1;
					end else begin
						r_q     <= hd;
						state_q <= S_AREAD;
					end
				end
				S_AREAD: begin
					head_q[o_q[OIW-1:0]] <= rdat.nxt;
					nx_q    <= rdat.nxt;
					state_q <= (rdat.nxt < NIL) ? S_ANPREV : S_SPLIT;
				end
				S_ANPREV: begin
					state_q <= S_SPLIT;
				end
				S_SPLIT: begin
					if (o_q > ord_q) begin
						o_q <= om1;
						if (u < (PW + 1)'(pages_q)) begin
							pp_q    <= u[PW-1:0];
							state_q <= S_PUSH;
						end
					end else begin
						res_q   <= '{status: bpa_pkg::ST_OK, page_index: bpa_pkg::IDX_W'(r_q)};
						state_q <= S_FIN;
					end
				end
				S_PUSH: begin
					head_q[o_q[OIW-1:0]] <= pp_q;
					nx_q <= hd;
					if (hd < NIL && hd != pp_q) begin
						state_q <= S_PUSH2;
					end else if (kind_q == bpa_pkg::KIND_ALLOC) begin
						state_q <= S_SPLIT;
					end else begin
						res_q   <= '{status: bpa_pkg::ST_OK, page_index: '0};
						state_q <= S_FIN;
					end
				end
				S_PUSH2: begin
					if (kind_q == bpa_pkg::KIND_ALLOC) begin
						state_q <= S_SPLIT;
					end else begin
						res_q   <= '{status: bpa_pkg::ST_OK, page_index: '0};
						state_q <= S_FIN;
					end
				end
				S_FCHK: begin
					if (chk_ok) begin
						b_q     <= bx;
						state_q <= S_FTAG;
					end else begin
						pp_q    <= cur_q;
						state_q <= S_PUSH;
					end
				end
				S_FTAG: begin
					if (rdat.tag != o_q) begin
						pp_q    <= cur_q;
						state_q <= S_PUSH;
					end else begin
						pv_q <= rdat.prv;
						nx_q <= rdat.nxt;
						o_q  <= o_q + 4'd1;
						if (b_q < cur_q) begin
							cur_q <= b_q;
						end
						if (rdat.prv >= NIL) begin
							head_q[o_q[OIW-1:0]] <= rdat.nxt;
							state_q <= (rdat.nxt < NIL) ? S_FUNN : S_FCHK;
						end else begin
							state_q <= S_FUNP;
						end
					end
				end
				S_FUNP: begin
					state_q <= (nx_q < NIL) ? S_FUNN : S_FCHK;
				end
				S_FUNN: begin
					state_q <= S_FCHK;
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_LAY;
				end
			endcase
			if (cfg_we) begin
				usable_q <= cfg_wdata;
				state_q  <= S_LAY;
			end
		end
	end

	a_cfg_relayout: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> state_q == S_LAY)
		else $error("page count write did not restart the layout");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !cfg_we) |=> !in_ready)
		else $error("request taken while another is in progress");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready && !cfg_we) |=> res_valid && $stable(res))
		else $error("pending result changed before it was taken");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_FIN) |-> !ram_we)
		else $error("page memory written while no request is active");

endmodule

// ----- hdl/buddy_page_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy page allocator core
// Allocates and frees power-of-two page blocks from per-order free lists kept
// in one page memory, with a registered result stage toward the consumer.
// ----------------------------------------------------------------------------
//
// Channel   Dir   Handshake            Payload
// s_*       in    s_tvalid/s_tready    tuser: kind; tdata: order, page_index
// m_*       out   m_tvalid/m_tready    tuser: status; tdata: page_index_out
// cfg_*     in    cfg_we               cfg_wdata: usable_pages
//
// One request is worked on at a time. The page memory has one read port, one
// write port and a registered read, and each list link is a read, modify and
// write back. After reset and after every cfg_we pulse the core lays out the
// free lists, sweeping every page entry once, while s_tready stays low.
// A finished result waits in the output register, so a stalled m_tready
// delays only the request after the next one.
//
module buddy_page_allocator_core #(
	parameter int unsigned MAX_PAGES   = 1024,
	parameter int unsigned ORDER_COUNT = 11
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Page count register.
	input  logic                               cfg_we,
	input  logic [bpa_pkg::CFG_W-1:0]          cfg_wdata,
	// Requests.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [bpa_pkg::IN_TDATA_W-1:0]     s_tdata,  // order[3:0], page_index[13:4]
	input  logic                               s_tuser,  // kind[0]
	// Results.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [bpa_pkg::OUT_TDATA_W-1:0]    m_tdata,  // page_index_out[9:0]
	output logic                               m_tuser   // status[0]
);

	localparam int unsigned AW = $clog2(MAX_PAGES);
	localparam int unsigned PW = $clog2(MAX_PAGES + 1);
	localparam int unsigned WW = bpa_pkg::TAG_W + 2 * PW;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [WW-1:0] ram_wdata, ram_rdata;

	logic          res_valid, res_ready;
	bpa_pkg::res_t res;

	// Page memory: each entry holds the page's tag and its two list links.
	bpa_ram #(
		.WIDTH (WW),
		.DEPTH (MAX_PAGES)
	) u_page_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bpa_ctrl #(
		.MAX_PAGES   (MAX_PAGES),
		.ORDER_COUNT (ORDER_COUNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser),
		.in_order  (s_tdata[3:0]),
		.in_page   (s_tdata[13:4]),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// Output register: loads when empty or when its content leaves this cycle.
	logic          m_valid_q;
	bpa_pkg::res_t m_res_q;

	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				m_valid_q <= 1'b1;
				m_res_q   <= res;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_res_q.status;
	assign m_tdata  = bpa_pkg::OUT_TDATA_W'(m_res_q.page_index);

endmodule
